### hdl/tama_pkg.sv
// Shared types and constants for the three-axis moving-average unit.
`default_nettype none

package tama_pkg;

   // Number of axes handled by the unit
   localparam int AXES = 3;
   // Width of one sample and of one mean
   localparam int SAMPLE_W = 16;
   // Width of the reported fill count
   localparam int FILLED_W = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [1:0] axis_type;
   localparam axis_type LAST_AXIS = axis_type'(AXES - 1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture the incoming request
      logic rd_en;      // read the entries about to be overwritten
      logic update;     // write the stores, update running sums, pointer and count
      logic div_load;   // load the divider with the selected axis sum
      logic div_step;   // one restoring division step
      logic div_store;  // sign-correct the quotient and keep it as the axis mean
      logic load_out;   // move the means into the output register
   } cmd_type;

endpackage : tama_pkg

`default_nettype wire

### hdl/tama_ctrl.sv
// Controller state machine: handshakes, sequencing of update and shared divider.
`default_nettype none

module tama_ctrl #(
   parameter int SUM_W = 21
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      tama_pkg::cmd_type cmd,
   output      tama_pkg::axis_type sel
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   tama_pkg::axis_type axis_ff, axis_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // Output register can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            axis_in    = '0;
            state_in   = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (axis_ff == tama_pkg::LAST_AXIS) begin
               state_in = ST_FINISH;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign sel       = axis_ff;

endmodule : tama_ctrl

`default_nettype wire

### hdl/tama_dp.sv
// Datapath: sample stores, running sums, fill count and shared serial divider.
`default_nettype none

module tama_dp #(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 21
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tama_pkg::cmd_type    cmd,
   input  wire tama_pkg::axis_type   sel,
   input  wire tama_pkg::sample_type sample_in [tama_pkg::AXES],
   output      tama_pkg::sample_type mean_out  [tama_pkg::AXES],
   output      logic [tama_pkg::FILLED_W-1:0] filled_out
);

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

   tama_pkg::sample_type sample_ff [tama_pkg::AXES];
   tama_pkg::sample_type old_ff    [tama_pkg::AXES];
   logic signed [SUM_W-1:0] sum_ff [tama_pkg::AXES];
   tama_pkg::sample_type mean_ff   [tama_pkg::AXES];
   tama_pkg::sample_type out_ff    [tama_pkg::AXES];
   logic [tama_pkg::FILLED_W-1:0] filled_ff;

   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full;

   // Divider registers
   logic [CNT_W-1:0] rem_ff;
   logic [SUM_W-1:0] quo_ff;
   logic             neg_ff;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             geq;
   logic signed [SUM_W-1:0] sel_sum;
   logic [SUM_W-1:0] sel_mag;
   logic [SUM_W-1:0] quo_signed;
   logic [CNT_W+tama_pkg::FILLED_W-1:0] count_ext;

   assign full = (count_ff == FULL_CNT);

   // Write pointer and fill count
   always_comb begin
      pos_in   = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      count_in = full ? count_ff : count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   // Per-axis ring store and running sum
   for (genvar a = 0; a < tama_pkg::AXES; a++) begin : g_axis
      logic [tama_pkg::SAMPLE_W-1:0] mem [WINDOW];
      logic signed [SUM_W-1:0] sum_in;

      // Single-port store: write the new sample, registered read of the old one
      always_ff @(posedge clock) begin
         if (cmd.update) begin
            mem[pos_ff] <= sample_ff[a];
         end
         if (cmd.rd_en) begin
            old_ff[a] <= mem[pos_ff];
         end
      end

      // Drop the overwritten entry once full, add the new one
      always_comb begin
         sum_in = sum_ff[a] + SUM_W'(sample_ff[a]);
         if (full) begin
            sum_in = sum_in - SUM_W'(old_ff[a]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[a] <= '0;
         end else if (cmd.update) begin
            sum_ff[a] <= sum_in;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.load_req) begin
            sample_ff[a] <= sample_in[a];
         end
      end
   end

   // Magnitude of the selected sum for the divider
   assign sel_sum = sum_ff[sel];
   assign sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

   // Restoring division, one quotient bit per step
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign geq   = (trial >= {1'b0, count_ff});
   assign diff  = trial - {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= sel_mag;
         neg_ff <= sel_sum[SUM_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= geq ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], geq};
      end
   end

   // Truncation toward zero: negate the magnitude quotient for a negative sum
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         mean_ff[sel] <= quo_signed[tama_pkg::SAMPLE_W-1:0];
      end
   end

   // Output register
   assign count_ext = {{tama_pkg::FILLED_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff    <= mean_ff;
         filled_ff <= count_ext[tama_pkg::FILLED_W-1:0];
      end
   end

   assign mean_out   = out_ff;
   assign filled_out = filled_ff;

endmodule : tama_dp

`default_nettype wire

### hdl/three_axis_moving_average_unit.sv
// Top level of the three-axis moving-average unit.
// Each accepted request carries one signed 16-bit sample per axis; the unit writes them
// into three ring stores of WINDOW entries, keeps a running sum per axis and returns one
// response with the three averages of the filled entries (truncated toward zero) and the
// fill count, which saturates at WINDOW. The sums are SUM_W = 17 + clog2(WINDOW) bits
// wide, and the means come from one shared bit-serial divider that works through the
// three axes in turn. One request is in flight at a time; req_stall is high while it is
// processed, and the output register lets a new request be accepted while the previous
// response still waits. No clearing pass is needed after reset.
`default_nettype none

module three_axis_moving_average_unit #(
   parameter int WINDOW = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire tama_pkg::sample_type req_sample_x,
   input  wire tama_pkg::sample_type req_sample_y,
   input  wire tama_pkg::sample_type req_sample_z,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      tama_pkg::sample_type rsp_mean_x,
   output      tama_pkg::sample_type rsp_mean_y,
   output      tama_pkg::sample_type rsp_mean_z,
   output      logic [tama_pkg::FILLED_W-1:0] rsp_filled
);

   localparam int SUM_W = tama_pkg::SAMPLE_W + $clog2(WINDOW) + 1;

   tama_pkg::cmd_type    cmd;
   tama_pkg::axis_type   sel;
   tama_pkg::sample_type samples [tama_pkg::AXES];
   tama_pkg::sample_type means   [tama_pkg::AXES];

   assign samples[0] = req_sample_x;
   assign samples[1] = req_sample_y;
   assign samples[2] = req_sample_z;

   // Sequencing
   tama_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sel       (sel)
   );

   // Stores, sums and divider
   tama_dp #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sel        (sel),
      .sample_in  (samples),
      .mean_out   (means),
      .filled_out (rsp_filled)
   );

   assign rsp_mean_x = means[0];
   assign rsp_mean_y = means[1];
   assign rsp_mean_z = means[2];

endmodule : three_axis_moving_average_unit

`default_nettype wire
